### design/mrea_pkg.sv
`timescale 1ns / 1ps
// Package for the ModR/M effective address unit.
// Holds field widths, mod/rm/override codes and pipeline stage records; no dependencies.
package mrea_pkg;

  localparam int unsigned AddrBitsDefault = 20;
  localparam int unsigned LinWidth        = 20;
  localparam int unsigned InDataWidth     = 152;
  localparam int unsigned InUserWidth     = 3;
  localparam int unsigned OutDataWidth    = 80;
  localparam int unsigned OutUserWidth    = 1;

  localparam logic [1:0] MOD_NODISP = 2'd0;
  localparam logic [1:0] MOD_DISP8  = 2'd1;
  localparam logic [1:0] MOD_DISP16 = 2'd2;
  localparam logic [1:0] MOD_REG    = 2'd3;

  localparam logic [2:0] RM_BX_SI = 3'd0;
  localparam logic [2:0] RM_BX_DI = 3'd1;
  localparam logic [2:0] RM_BP_SI = 3'd2;
  localparam logic [2:0] RM_BP_DI = 3'd3;
  localparam logic [2:0] RM_SI    = 3'd4;
  localparam logic [2:0] RM_DI    = 3'd5;
  localparam logic [2:0] RM_BP    = 3'd6;
  localparam logic [2:0] RM_BX    = 3'd7;

  localparam logic [1:0] EXTRA_NONE = 2'd0;
  localparam logic [1:0] EXTRA_ONE  = 2'd1;
  localparam logic [1:0] EXTRA_TWO  = 2'd2;

  typedef enum logic [2:0] {
    OVR_NONE = 3'd0,
    OVR_ES   = 3'd1,
    OVR_CS   = 3'd2,
    OVR_SS   = 3'd3,
    OVR_DS   = 3'd4
  } seg_ovr_t;

  typedef struct packed {
    logic [1:0]  mod_field;
    logic [2:0]  reg_field;
    logic [2:0]  rm_field;
    logic        is_register;
    logic [15:0] opnd_a;
    logic [15:0] opnd_b;
    logic [15:0] displacement;
    logic [15:0] segment_value;
    logic [1:0]  extra_bytes;
  } dec_t;

  typedef struct packed {
    logic [1:0]  mod_field;
    logic [2:0]  reg_field;
    logic [2:0]  rm_field;
    logic        is_register;
    logic [15:0] effective_offset;
    logic [15:0] displacement;
    logic [15:0] segment_value;
    logic [1:0]  extra_bytes;
  } ofs_t;

  typedef struct packed {
    logic [1:0]  mod_field;
    logic [2:0]  reg_field;
    logic [2:0]  rm_field;
    logic        is_register;
    logic [15:0] effective_offset;
    logic [15:0] displacement;
    logic [15:0] segment_value;
    logic [19:0] linear_address;
    logic [1:0]  extra_bytes;
  } res_t;

endpackage

### design/modrm_effective_address_unit.sv
`timescale 1ns / 1ps
// 8086 16-bit ModR/M effective address unit: decode, offset add, linear address.
// Depends on mrea_pkg.
//
// Each request carries one ModR/M byte with the two bytes after it, BX/BP/SI/DI,
// the four segment registers and an override code; each gives exactly one result.
// The unit is a three-stage pipeline (decode and operand select, 16-bit offset
// add, segment shift-add); a request moves through dec_r, ofs_r and res_r, and
// one is taken every cycle unless stalled. The output stage is a register;
// in_tready drops only when every stage holds a request and out_tready is low.
// Register forms (mod 3) give zero offset, displacement, segment, linear address
// and byte count. The linear address is masked to ADDR_BITS, capped at 20 bits.
module modrm_effective_address_unit #(
  parameter int unsigned ADDR_BITS = mrea_pkg::AddrBitsDefault
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // modrm_byte[7:0], disp_lo[15:8], disp_hi[23:16], reg_bx[39:24], reg_bp[55:40],
  // reg_si[71:56], reg_di[87:72], seg_ds[103:88], seg_ss[119:104],
  // seg_es[135:120], seg_cs[151:136]
  input  logic [mrea_pkg::InDataWidth-1:0]    in_tdata,
  // seg_override[2:0]
  input  logic [mrea_pkg::InUserWidth-1:0]    in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // mod_field[1:0], reg_field[4:2], rm_field[7:5], effective_offset[23:8],
  // displacement[39:24], segment_value[55:40], linear_address[75:56],
  // extra_bytes[77:76], zero[79:78]
  output logic [mrea_pkg::OutDataWidth-1:0]   out_tdata,
  // is_register[0]
  output logic [mrea_pkg::OutUserWidth-1:0]   out_tuser
);
  import mrea_pkg::*;

  localparam int unsigned LinBits = (ADDR_BITS < LinWidth) ? ADDR_BITS : LinWidth;
  localparam logic [LinWidth-1:0] LinMask =
    LinWidth'((LinWidth + 1)'(1) << LinBits) - LinWidth'(1);

  logic [7:0]  modrm_byte;
  logic [7:0]  disp_lo;
  logic [7:0]  disp_hi;
  logic [15:0] reg_bx;
  logic [15:0] reg_bp;
  logic [15:0] reg_si;
  logic [15:0] reg_di;
  logic [15:0] seg_ds;
  logic [15:0] seg_ss;
  logic [15:0] seg_es;
  logic [15:0] seg_cs;
  logic [2:0]  seg_override;

  assign modrm_byte   = in_tdata[7:0];
  assign disp_lo      = in_tdata[15:8];
  assign disp_hi      = in_tdata[23:16];
  assign reg_bx       = in_tdata[39:24];
  assign reg_bp       = in_tdata[55:40];
  assign reg_si       = in_tdata[71:56];
  assign reg_di       = in_tdata[87:72];
  assign seg_ds       = in_tdata[103:88];
  assign seg_ss       = in_tdata[119:104];
  assign seg_es       = in_tdata[135:120];
  assign seg_cs       = in_tdata[151:136];
  assign seg_override = in_tuser[2:0];

  logic v1_r, v2_r, v3_r;
  logic v1_nxt, v2_nxt, v3_nxt;
  dec_t dec_r, dec_nxt;
  ofs_t ofs_r, ofs_nxt;
  res_t res_r, res_nxt;
  logic s1_ready, s2_ready, s3_ready;

  assign s3_ready  = !v3_r || out_tready;
  assign s2_ready  = !v2_r || s3_ready;
  assign s1_ready  = !v1_r || s2_ready;
  assign in_tready = s1_ready;

  // Stage 1: split the byte, pick base/index operands, displacement and segment.
  always_comb begin
    logic [1:0]  md;
    logic [2:0]  rm;
    logic        bp_based;
    logic [15:0] dflt_seg;
    md       = modrm_byte[7:6];
    rm       = modrm_byte[2:0];
    bp_based = 1'b0;

    dec_nxt               = '0;
    dec_nxt.mod_field     = md;
    dec_nxt.reg_field     = modrm_byte[5:3];
    dec_nxt.rm_field      = rm;
    dec_nxt.is_register   = (md == MOD_REG);

    unique case (rm)
      RM_BX_SI: begin
        dec_nxt.opnd_a = reg_bx;
        dec_nxt.opnd_b = reg_si;
      end
      RM_BX_DI: begin
        dec_nxt.opnd_a = reg_bx;
        dec_nxt.opnd_b = reg_di;
      end
      RM_BP_SI: begin
        dec_nxt.opnd_a = reg_bp;
        dec_nxt.opnd_b = reg_si;
        bp_based       = 1'b1;
      end
      RM_BP_DI: begin
        dec_nxt.opnd_a = reg_bp;
        dec_nxt.opnd_b = reg_di;
        bp_based       = 1'b1;
      end
      RM_SI: dec_nxt.opnd_a = reg_si;
      RM_DI: dec_nxt.opnd_a = reg_di;
      RM_BP: begin
        if (md != MOD_NODISP) begin
          dec_nxt.opnd_a = reg_bp;
          bp_based       = 1'b1;
        end
      end
      RM_BX: dec_nxt.opnd_a = reg_bx;
      default: dec_nxt.opnd_a = '0;
    endcase

    unique case (md)
      MOD_NODISP: begin
        if (rm == RM_BP) begin
          dec_nxt.displacement = {disp_hi, disp_lo};
          dec_nxt.extra_bytes  = EXTRA_TWO;
        end
      end
      MOD_DISP8: begin
        dec_nxt.displacement = {{8{disp_lo[7]}}, disp_lo};
        dec_nxt.extra_bytes  = EXTRA_ONE;
      end
      MOD_DISP16: begin
        dec_nxt.displacement = {disp_hi, disp_lo};
        dec_nxt.extra_bytes  = EXTRA_TWO;
      end
      default: dec_nxt.extra_bytes = EXTRA_NONE;
    endcase

    dflt_seg = bp_based ? seg_ss : seg_ds;
    unique case (seg_override)
      OVR_ES:  dec_nxt.segment_value = seg_es;
      OVR_CS:  dec_nxt.segment_value = seg_cs;
      OVR_SS:  dec_nxt.segment_value = seg_ss;
      OVR_DS:  dec_nxt.segment_value = seg_ds;
      default: dec_nxt.segment_value = dflt_seg;
    endcase

    if (md == MOD_REG) begin
      dec_nxt.opnd_a        = '0;
      dec_nxt.opnd_b        = '0;
      dec_nxt.displacement  = '0;
      dec_nxt.segment_value = '0;
      dec_nxt.extra_bytes   = EXTRA_NONE;
    end
  end

  // Stage 2: offset wraps modulo 2^16.
  always_comb begin
    ofs_nxt.mod_field        = dec_r.mod_field;
    ofs_nxt.reg_field        = dec_r.reg_field;
    ofs_nxt.rm_field         = dec_r.rm_field;
    ofs_nxt.is_register      = dec_r.is_register;
    ofs_nxt.effective_offset = dec_r.opnd_a + dec_r.opnd_b + dec_r.displacement;
    ofs_nxt.displacement     = dec_r.displacement;
    ofs_nxt.segment_value    = dec_r.segment_value;
    ofs_nxt.extra_bytes      = dec_r.extra_bytes;
  end

  // Stage 3: segment * 16 + offset, masked to the address width.
  always_comb begin
    res_nxt.mod_field        = ofs_r.mod_field;
    res_nxt.reg_field        = ofs_r.reg_field;
    res_nxt.rm_field         = ofs_r.rm_field;
    res_nxt.is_register      = ofs_r.is_register;
    res_nxt.effective_offset = ofs_r.effective_offset;
    res_nxt.displacement     = ofs_r.displacement;
    res_nxt.segment_value    = ofs_r.segment_value;
    res_nxt.extra_bytes      = ofs_r.extra_bytes;
    res_nxt.linear_address   = ({ofs_r.segment_value, 4'b0000}
                               + {4'b0000, ofs_r.effective_offset}) & LinMask;
  end

  assign v1_nxt = s1_ready ? in_tvalid : v1_r;
  assign v2_nxt = s2_ready ? v1_r      : v2_r;
  assign v3_nxt = s3_ready ? v2_r      : v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      dec_r <= dec_nxt;
    end
    if (s2_ready) begin
      ofs_r <= ofs_nxt;
    end
    if (s3_ready) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tuser  = res_r.is_register;
  assign out_tdata  = {2'b00,
                       res_r.extra_bytes,
                       res_r.linear_address,
                       res_r.segment_value,
                       res_r.displacement,
                       res_r.effective_offset,
                       res_r.rm_field,
                       res_r.reg_field,
                       res_r.mod_field};

  a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v1_r)
    else $error("accepted request did not enter stage 1");

  a_register_form_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_r.is_register) |->
      (res_r.effective_offset == '0 && res_r.linear_address == '0
       && res_r.extra_bytes == EXTRA_NONE && res_r.segment_value == '0))
    else $error("register form result carries address data");

  a_mod_matches_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((res_r.mod_field == MOD_REG) == res_r.is_register))
    else $error("is_register disagrees with mod field");

  a_extra_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res_r.extra_bytes != 2'd3))
    else $error("displacement byte count out of range");

  a_stall_holds_stage3: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !out_tready) |=> (v3_r && $stable(res_r.linear_address)))
    else $error("stalled result lost or changed");

endmodule
